// File: design/lsv_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lsv_pkg: shared definitions for the LRU victim select block
// Field widths, defaults, request codes and sequencer states.
// ----------------------------------------------------------------------------
package lsv_pkg;

  localparam int DefWays        = 16;
  localparam int DefMaxAttempts = 4;

  localparam int MaskW    = 16;
  localparam int WayOutW  = 4;
  localparam int AttOutW  = 2;
  localparam int CfgW     = 3;

  localparam logic [CfgW-1:0] AttemptLimitRst = 3'd1;

  localparam logic ReqAccess = 1'b0;
  localparam logic ReqFill   = 1'b1;

  typedef enum logic [1:0] {
    StIdle,
    StAccess,
    StSearch,
    StDecide
  } lsv_state_e;

endpackage
`default_nettype wire

// File: design/lsv_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lsv_cell: replacement state of one way
// Holds the way's age and loop bit, applies the MRU broadcast and folds
// itself into the running oldest-way and first-invalid-way search word.
// ----------------------------------------------------------------------------
module lsv_cell #(
  parameter int WAYS = lsv_pkg::DefWays,
  parameter int IDX  = 0
) (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire [$clog2(WAYS)*2+2:0]  upd_i,
  input  wire                       repl_i,
  input  wire                       valid_i,
  input  wire                       lower_i,
  input  wire [$clog2(WAYS)*5+3:0]  link_i,
  output logic [$clog2(WAYS)*5+3:0] link_o,
  output logic [$clog2(WAYS)-1:0]   age_o
);

  localparam int IW = $clog2(WAYS);

  typedef struct packed {
    logic          en;
    logic [IW-1:0] idx;
    logic [IW-1:0] age;
    logic          loop_we;
    logic          loop_val;
  } upd_t;

  typedef struct packed {
    logic [IW-1:0] best;
    logic [IW-1:0] cand;
    logic [IW-1:0] cand_age;
    logic          cand_loop;
    logic          cand_lower;
    logic          inv_found;
    logic [IW-1:0] inv_idx;
    logic [IW-1:0] inv_age;
    logic          inv_loop;
  } link_t;

  upd_t          upd;
  link_t         lk_in;
  link_t         lk_d, lk_q;
  logic [IW-1:0] age_d, age_q;
  logic          loop_d, loop_q;
  logic          is_tgt;
  logic          older;
  logic          take;

  assign upd   = upd_t'(upd_i);
  assign lk_in = link_t'(link_i);

  assign is_tgt = (upd.idx == IW'(IDX));

  always_comb begin
    age_d  = age_q;
    loop_d = loop_q;
    if (upd.en) begin
      if (is_tgt) begin
        age_d = '0;
      end else if (age_q < upd.age) begin
        age_d = age_q + 1'b1;
      end
      if (upd.loop_we && is_tgt) begin
        loop_d = upd.loop_val;
      end
    end
  end

  // way 0 is the fallback candidate, so it always seeds the candidate fields
  assign older = repl_i && (age_q > lk_in.best);
  assign take  = older || (IDX == 0);

  always_comb begin
    lk_d = lk_in;
    if (older) begin
      lk_d.best = age_q;
    end
    if (take) begin
      lk_d.cand       = IW'(IDX);
      lk_d.cand_age   = age_q;
      lk_d.cand_loop  = loop_q;
      lk_d.cand_lower = lower_i;
    end
    if (!lk_in.inv_found && !valid_i) begin
      lk_d.inv_found = 1'b1;
      lk_d.inv_idx   = IW'(IDX);
      lk_d.inv_age   = age_q;
      lk_d.inv_loop  = loop_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      age_q  <= IW'(IDX);
      loop_q <= 1'b0;
    end else begin
      age_q  <= age_d;
      loop_q <= loop_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lk_q <= lk_d;
  end

  assign link_o = lk_q;
  assign age_o  = age_q;

endmodule
`default_nettype wire

// File: design/lsv_chain.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lsv_chain: row of way cells
// Spreads the per-way mask bits over the cells and links each cell's
// search word to its neighbour; the tail carries the finished search.
// ----------------------------------------------------------------------------
module lsv_chain #(
  parameter int WAYS = lsv_pkg::DefWays
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire [$clog2(WAYS)*2+2:0]             upd_i,
  input  wire [lsv_pkg::MaskW-1:0]             valid_mask_i,
  input  wire [lsv_pkg::MaskW-1:0]             repl_mask_i,
  input  wire [lsv_pkg::MaskW-1:0]             lower_mask_i,
  output logic [$clog2(WAYS)*5+3:0]            tail_o,
  output logic [WAYS-1:0][$clog2(WAYS)-1:0]    ages_o
);

  localparam int IW = $clog2(WAYS);
  localparam int LinkW = IW * 5 + 4;

  logic [WAYS:0][LinkW-1:0] link;

  assign link[0] = '0;

  for (genvar i = 0; i < WAYS; i++) begin : g_cell
    logic valid_b, repl_b, lower_b;

    // ways beyond the mask width read as invalid, not replaceable, not held below
    if (i < lsv_pkg::MaskW) begin : g_in
      assign valid_b = valid_mask_i[i];
      assign repl_b  = repl_mask_i[i];
      assign lower_b = lower_mask_i[i];
    end else begin : g_out
      assign valid_b = 1'b0;
      assign repl_b  = 1'b0;
      assign lower_b = 1'b0;
    end

    lsv_cell #(
      .WAYS(WAYS),
      .IDX (i)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .upd_i  (upd_i),
      .repl_i (repl_b),
      .valid_i(valid_b),
      .lower_i(lower_b),
      .link_i (link[i]),
      .link_o (link[i+1]),
      .age_o  (ages_o[i])
    );
  end

  assign tail_o = link[WAYS];

endmodule
`default_nettype wire

// File: design/lru_set_loop_bit_victim_select_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lru_set_loop_bit_victim_select_top: true-LRU victim select for one set
// Per-way ages and loop bits live in a row of cells; a search word walks the
// row one cell per cycle, and a small sequencer applies MRU updates.
// ----------------------------------------------------------------------------
// Access word: busy in the access state after acceptance, result strobed the cycle after.
// Fill word: busy for n attempts, n = attempts taken (1..limit); each attempt is
//   a walk of the search word down the cell row plus the decide state. Next word
//   is accepted in the cycle the result is strobed.
// The receiver cannot stall; each result stands for exactly one cycle.
// Reset: way i gets age i, all loop bits clear, attempt limit 1, block idle.
module lru_set_loop_bit_victim_select_top #(
  parameter int WAYS         = lsv_pkg::DefWays,
  parameter int MAX_ATTEMPTS = lsv_pkg::DefMaxAttempts
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  // configuration
  input  wire                          cfg_we_i,
  input  wire [lsv_pkg::CfgW-1:0]      cfg_wdata_i,
  // command word
  input  wire                          start,
  output logic                         busy,
  input  wire                          req_type_i,
  input  wire [lsv_pkg::WayOutW-1:0]   way_index_i,
  input  wire                          write_access_i,
  input  wire                          l3_hit_i,
  input  wire [lsv_pkg::MaskW-1:0]     valid_mask_i,
  input  wire [lsv_pkg::MaskW-1:0]     replaceable_mask_i,
  input  wire [lsv_pkg::MaskW-1:0]     in_lower_mask_i,
  // result word
  output logic                         done_o,
  output logic [lsv_pkg::WayOutW-1:0]  victim_way_o,
  output logic                         evicted_loop_bit_o,
  output logic [lsv_pkg::AttOutW-1:0]  attempts_used_o
);

  localparam int IW = $clog2(WAYS);
  localparam int LW = $clog2(MAX_ATTEMPTS + 1);

  typedef struct packed {
    logic          en;
    logic [IW-1:0] idx;
    logic [IW-1:0] age;
    logic          loop_we;
    logic          loop_val;
  } upd_t;

  typedef struct packed {
    logic [IW-1:0] best;
    logic [IW-1:0] cand;
    logic [IW-1:0] cand_age;
    logic          cand_loop;
    logic          cand_lower;
    logic          inv_found;
    logic [IW-1:0] inv_idx;
    logic [IW-1:0] inv_age;
    logic          inv_loop;
  } link_t;

  lsv_pkg::lsv_state_e state_d, state_q;

  logic [lsv_pkg::CfgW-1:0]    limit_cfg_q;
  logic [LW-1:0]               limit_eff;
  logic [IW-1:0]               cnt_d, cnt_q;
  logic [LW-1:0]               att_d, att_q;

  // latched command word
  logic [lsv_pkg::WayOutW-1:0] way_q;
  logic                        wr_q;
  logic                        hit_q;
  logic [lsv_pkg::MaskW-1:0]   valid_q, repl_q, lower_q;

  // result registers
  logic                        done_d, done_q;
  logic [lsv_pkg::WayOutW-1:0] victim_d, victim_q;
  logic                        evl_d, evl_q;
  logic [lsv_pkg::AttOutW-1:0] attu_d, attu_q;

  upd_t                        upd;
  link_t                       tail;
  logic [IW*5+3:0]             tail_raw;
  logic [WAYS-1:0][IW-1:0]     ages;
  logic                        acc_in_range;
  logic                        accept;

  assign accept = start && !busy;
  assign busy   = (state_q != lsv_pkg::StIdle);

  // zero means one attempt; clamp to the supported maximum
  always_comb begin
    if (limit_cfg_q == '0) begin
      limit_eff = LW'(1);
    end else if (32'(limit_cfg_q) > MAX_ATTEMPTS) begin
      limit_eff = LW'(MAX_ATTEMPTS);
    end else begin
      limit_eff = LW'(limit_cfg_q);
    end
  end

  assign acc_in_range = (32'(way_q) < WAYS);
  assign tail         = link_t'(tail_raw);

  lsv_chain #(
    .WAYS(WAYS)
  ) u_chain (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .upd_i       (upd),
    .valid_mask_i(valid_q),
    .repl_mask_i (repl_q),
    .lower_mask_i(lower_q),
    .tail_o      (tail_raw),
    .ages_o      (ages)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lsv_pkg::StIdle;
      limit_cfg_q <= lsv_pkg::AttemptLimitRst;
      cnt_q       <= '0;
      att_q       <= '0;
      done_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      att_q   <= att_d;
      done_q  <= done_d;
      if (cfg_we_i) begin
        limit_cfg_q <= cfg_wdata_i;
      end
    end
  end

  // payload: hold the command word for the whole job, hold results till the next
  always_ff @(posedge clk_i) begin
    if (accept) begin
      way_q   <= way_index_i;
      wr_q    <= write_access_i;
      hit_q   <= l3_hit_i;
      valid_q <= valid_mask_i;
      repl_q  <= replaceable_mask_i;
      lower_q <= in_lower_mask_i;
    end
    if (done_d) begin
      victim_q <= victim_d;
      evl_q    <= evl_d;
      attu_q   <= attu_d;
    end
  end

  // Sequencer: the search word must pass every cell in settled state to reach
  // the tail, so every MRU update is followed by a fresh walk down the row.
  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    att_d    = att_q;
    done_d   = 1'b0;
    victim_d = '0;
    evl_d    = 1'b0;
    attu_d   = '0;
    upd      = '0;

    unique case (state_q)
      lsv_pkg::StIdle: begin
        if (accept) begin
          cnt_d = '0;
          att_d = '0;
          if (req_type_i == lsv_pkg::ReqFill) begin
            state_d = lsv_pkg::StSearch;
          end else begin
            state_d = lsv_pkg::StAccess;
          end
        end
      end

      lsv_pkg::StAccess: begin
        // out-of-range way leaves the state untouched but is still echoed
        upd.en       = acc_in_range;
        upd.idx      = IW'(way_q);
        upd.age      = ages[IW'(way_q)];
        upd.loop_we  = wr_q;
        upd.loop_val = 1'b0;
        done_d       = 1'b1;
        victim_d     = way_q;
        state_d      = lsv_pkg::StIdle;
      end

      lsv_pkg::StSearch: begin
        if (cnt_q == IW'(WAYS - 1)) begin
          state_d = lsv_pkg::StDecide;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end

      lsv_pkg::StDecide: begin
        if (att_q == '0 && tail.inv_found) begin
          // lowest invalid way wins outright
          upd.en       = 1'b1;
          upd.idx      = tail.inv_idx;
          upd.age      = tail.inv_age;
          upd.loop_we  = 1'b1;
          upd.loop_val = hit_q;
          done_d       = 1'b1;
          victim_d     = lsv_pkg::WayOutW'(tail.inv_idx);
          evl_d        = tail.inv_loop;
          state_d      = lsv_pkg::StIdle;
        end else if ((32'(att_q) + 1 < 32'(limit_eff)) && tail.cand_lower) begin
          // candidate still held below: promote it and search again
          upd.en  = 1'b1;
          upd.idx = tail.cand;
          upd.age = tail.cand_age;
          att_d   = att_q + 1'b1;
          cnt_d   = '0;
          state_d = lsv_pkg::StSearch;
        end else begin
          upd.en       = 1'b1;
          upd.idx      = tail.cand;
          upd.age      = tail.cand_age;
          upd.loop_we  = 1'b1;
          upd.loop_val = hit_q;
          done_d       = 1'b1;
          victim_d     = lsv_pkg::WayOutW'(tail.cand);
          evl_d        = tail.cand_loop;
          if (32'(att_q) > 3) begin
            attu_d = lsv_pkg::AttOutW'(3);
          end else begin
            attu_d = lsv_pkg::AttOutW'(att_q);
          end
          state_d = lsv_pkg::StIdle;
        end
      end

      default: begin
        state_d = lsv_pkg::StIdle;
      end
    endcase
  end

  assign done_o             = done_q;
  assign victim_way_o       = victim_q;
  assign evicted_loop_bit_o = evl_q;
  assign attempts_used_o    = attu_q;

  // a result strobe never lasts beyond one cycle
  a_strobe_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("result strobe held for more than one cycle");

  // a result only follows a busy cycle
  a_strobe_after_work : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> ($past(state_q) != lsv_pkg::StIdle))
    else $error("result strobe without preceding work");

  // an accepted word always leaves idle
  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("accepted word did not start work");

  // valid mask is fixed for the job, so retries never see an invalid way
  a_retry_no_invalid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lsv_pkg::StDecide && att_q != '0) |-> !tail.inv_found)
    else $error("invalid way found on a retry attempt");

endmodule
`default_nettype wire

// File: dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the LRU victim select block
// Drives access and fill words through the start/busy handshake, predicts
// every result word from a private copy of the per-way ages, loop bits and
// attempt limit, and checks each strobed result against the oldest prediction.
// Directed words cover the corner cases; random traffic covers the rest under
// every attempt limit setting, including zero and values past the maximum.
// ----------------------------------------------------------------------------
module tb;

  localparam int Ways          = lsv_pkg::DefWays;
  localparam int MaxAttempts   = lsv_pkg::DefMaxAttempts;
  localparam int WatchdogLimit = 2000;
  localparam int MaxShown      = 10;
  localparam int TailCycles    = 80;
  localparam int WordsPerLimit = 112;

  // One command word as presented on the input ports.
  typedef struct packed {
    logic                          req;
    logic [lsv_pkg::WayOutW-1:0]   way;
    logic                          wr;
    logic                          hit;
    logic [lsv_pkg::MaskW-1:0]     valid;
    logic [lsv_pkg::MaskW-1:0]     repl;
    logic [lsv_pkg::MaskW-1:0]     lower;
  } cmd_word_t;

  // One result word as strobed on the output ports.
  typedef struct packed {
    logic [lsv_pkg::WayOutW-1:0]   way;
    logic                          loop;
    logic [lsv_pkg::AttOutW-1:0]   att;
  } victim_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [lsv_pkg::CfgW-1:0]      cfg_wdata_i;
  logic                          start;
  logic                          busy;
  logic                          req_type_i;
  logic [lsv_pkg::WayOutW-1:0]   way_index_i;
  logic                          write_access_i;
  logic                          l3_hit_i;
  logic [lsv_pkg::MaskW-1:0]     valid_mask_i;
  logic [lsv_pkg::MaskW-1:0]     replaceable_mask_i;
  logic [lsv_pkg::MaskW-1:0]     in_lower_mask_i;
  logic                          done_o;
  logic [lsv_pkg::WayOutW-1:0]   victim_way_o;
  logic                          evicted_loop_bit_o;
  logic [lsv_pkg::AttOutW-1:0]   attempts_used_o;

  // Predicted replacement state of the set.
  int                            pred_age [Ways];
  bit                            pred_loop[Ways];
  int                            pred_limit;

  victim_t                       pending_victims[$];
  int                            fault_count;
  int                            idle_cycles;
  int                            burst_left;

  lru_set_loop_bit_victim_select_top dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .start              (start),
    .busy               (busy),
    .req_type_i         (req_type_i),
    .way_index_i        (way_index_i),
    .write_access_i     (write_access_i),
    .l3_hit_i           (l3_hit_i),
    .valid_mask_i       (valid_mask_i),
    .replaceable_mask_i (replaceable_mask_i),
    .in_lower_mask_i    (in_lower_mask_i),
    .done_o             (done_o),
    .victim_way_o       (victim_way_o),
    .evicted_loop_bit_o (evicted_loop_bit_o),
    .attempts_used_o    (attempts_used_o)
  );

  always #1 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // Bring a way to MRU: every way younger than it ages by one.
  function automatic void promote_way(int w);
    int a;
    a = pred_age[w];
    for (int i = 0; i < Ways; i++) begin
      if (pred_age[i] < a) pred_age[i]++;
    end
    pred_age[w] = 0;
  endfunction

  // Apply one accepted word to the predicted state and return its result word.
  function automatic victim_t select_victim(cmd_word_t w);
    victim_t v;
    int      lim;
    int      att;
    int      cand;
    int      best;
    v = '{way: w.way, loop: 1'b0, att: '0};
    if (w.req == lsv_pkg::ReqAccess) begin
      if (w.wr) pred_loop[w.way] = 1'b0;
      promote_way(int'(w.way));
      return v;
    end
    // Lowest-numbered invalid way wins outright.
    for (int i = 0; i < Ways; i++) begin
      if (!w.valid[i]) begin
        promote_way(i);
        v.way  = i[lsv_pkg::WayOutW-1:0];
        v.loop = pred_loop[i];
        pred_loop[i] = w.hit;
        return v;
      end
    end
    // Zero means one attempt; anything past the maximum is clipped.
    lim = pred_limit;
    if (lim == 0) lim = 1;
    if (lim > MaxAttempts) lim = MaxAttempts;
    cand = 0;
    for (att = 0; att < lim; att++) begin
      best = 0;
      cand = 0;
      // Only a strictly older replaceable way displaces way 0.
      for (int i = 0; i < Ways; i++) begin
        if (pred_age[i] > best && w.repl[i]) begin
          cand = i;
          best = pred_age[i];
        end
      end
      // Retry while attempts remain if the lower level also holds the line.
      if (att + 1 < lim && w.lower[cand]) promote_way(cand);
      else break;
    end
    if (att >= lim) att = lim - 1;
    promote_way(cand);
    v.way  = cand[lsv_pkg::WayOutW-1:0];
    v.loop = pred_loop[cand];
    v.att  = (att > 3) ? 2'd3 : att[lsv_pkg::AttOutW-1:0];
    pred_loop[cand] = w.hit;
    return v;
  endfunction

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------

  task automatic note_fault(input string msg);
    fault_count++;
    if (fault_count <= MaxShown) $display("%0t: %s", $realtime, msg);
  endtask

  // The receiver cannot stall, so take every strobed word at the edge that
  // ends its cycle and hold it up against the oldest prediction.
  always @(posedge clk_i) begin
    victim_t got;
    victim_t want;
    if (rst_ni && done_o) begin
      got = '{way: victim_way_o, loop: evicted_loop_bit_o, att: attempts_used_o};
      if (pending_victims.size() == 0) begin
        note_fault($sformatf("unexpected result word: way %0d loop %0b att %0d",
                             got.way, got.loop, got.att));
      end else begin
        want = pending_victims.pop_front();
        if (got.way !== want.way || got.loop !== want.loop || got.att !== want.att) begin
          note_fault($sformatf({"result mismatch: want way %0d loop %0b att %0d, ",
                                "got way %0d loop %0b att %0d"},
                               want.way, want.loop, want.att,
                               got.way, got.loop, got.att));
        end
      end
    end
  end

  // Count edges at which no word moves in either direction; a hang ends here.
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  function automatic cmd_word_t make_word(logic req, logic [3:0] way, logic wr,
                                          logic hit, logic [15:0] valid,
                                          logic [15:0] repl, logic [15:0] lower);
    cmd_word_t w;
    w = '{req: req, way: way, wr: wr, hit: hit, valid: valid, repl: repl, lower: lower};
    return w;
  endfunction

  // Present one word, hold it until the block takes it, then log its result.
  // Bursts of back-to-back words are broken by short random gaps; a gap is
  // never zero so start is not dropped and raised in the same step.
  task automatic send_word(input cmd_word_t w);
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? 64 : $urandom_range(1, 16);
    end
    start              <= 1'b1;
    req_type_i         <= w.req;
    way_index_i        <= w.way;
    write_access_i     <= w.wr;
    l3_hit_i           <= w.hit;
    valid_mask_i       <= w.valid;
    replaceable_mask_i <= w.repl;
    in_lower_mask_i    <= w.lower;
    do @(posedge clk_i); while (busy);
    pending_victims.push_back(select_victim(w));
    burst_left--;
  endtask

  // Drop start and wait until every predicted word has come back.
  task automatic drain_words();
    start <= 1'b0;
    burst_left = 0;
    wait (pending_victims.size() == 0);
    repeat (2) @(posedge clk_i);
  endtask

  // Write the attempt limit with the block idle.
  task automatic write_limit(input logic [lsv_pkg::CfgW-1:0] value);
    drain_words();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    pred_limit = int'(value);
  endtask

  // Mostly fills of a full set, so the age search and the retry loop get
  // exercised; the rest are accesses and fills that find a free way.
  function automatic cmd_word_t random_word();
    cmd_word_t w;
    w.req   = ($urandom_range(0, 99) < 35) ? lsv_pkg::ReqAccess : lsv_pkg::ReqFill;
    w.way   = lsv_pkg::WayOutW'($urandom_range(0, Ways - 1));
    w.wr    = 1'($urandom_range(0, 1));
    w.hit   = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 9))
      8:       w.valid = 16'hFFFF & ~(16'h1 << $urandom_range(0, 15));
      9:       w.valid = 16'($urandom);
      default: w.valid = 16'hFFFF;
    endcase
    case ($urandom_range(0, 3))
      0:       w.repl = 16'hFFFF;
      1:       w.repl = 16'($urandom);
      2:       w.repl = 16'($urandom & $urandom);
      default: w.repl = ($urandom_range(0, 1) == 0) ? 16'h0 : 16'h1 << $urandom_range(0, 15);
    endcase
    case ($urandom_range(0, 3))
      0:       w.lower = 16'hFFFF;
      1:       w.lower = 16'($urandom);
      2:       w.lower = 16'($urandom | $urandom);
      default: w.lower = 16'h0;
    endcase
    return w;
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Accesses at both ends of the way range, reads and writes; the masks are
  // don't-care here so drive them all high once.
  task automatic test_access_extremes();
    send_word(make_word(lsv_pkg::ReqAccess, 4'd0,  1'b0, 1'b0, 16'h0, 16'h0, 16'h0));
    send_word(make_word(lsv_pkg::ReqAccess, 4'd15, 1'b1, 1'b0, 16'h0, 16'h0, 16'h0));
    send_word(make_word(lsv_pkg::ReqAccess, 4'd15, 1'b0, 1'b1,
                        16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_word(make_word(lsv_pkg::ReqAccess, 4'd0,  1'b1, 1'b1, 16'h0, 16'h0, 16'h0));
  endtask

  // Fills that land on a free way: lowest and highest free way, a loop bit
  // set by a fill and read back, then cleared by a write access.
  task automatic test_fill_free_way();
    send_word(make_word(lsv_pkg::ReqFill, 4'd9, 1'b0, 1'b1, 16'h0000, 16'h0, 16'h0));
    send_word(make_word(lsv_pkg::ReqFill, 4'd0, 1'b0, 1'b1, 16'h7FFF, 16'hFFFF, 16'h0));
    send_word(make_word(lsv_pkg::ReqFill, 4'd0, 1'b0, 1'b0, 16'hFFFE, 16'h0, 16'hFFFF));
    send_word(make_word(lsv_pkg::ReqFill, 4'd0, 1'b0, 1'b1, 16'hFFFE, 16'h0, 16'h0));
    send_word(make_word(lsv_pkg::ReqAccess, 4'd0, 1'b1, 1'b0, 16'h0, 16'h0, 16'h0));
    send_word(make_word(lsv_pkg::ReqFill, 4'd0, 1'b0, 1'b0, 16'hFFFE, 16'h0, 16'h0));
  endtask

  // Full set at the reset limit: oldest way taken, nothing replaceable falls
  // back to way 0, and a lone replaceable way that is MRU also yields way 0.
  task automatic test_fill_full_set();
    send_word(make_word(lsv_pkg::ReqFill, 4'd0, 1'b0, 1'b1, 16'hFFFF, 16'hFFFF, 16'h0));
    send_word(make_word(lsv_pkg::ReqFill, 4'd0, 1'b0, 1'b0, 16'hFFFF, 16'h0000, 16'h0));
    send_word(make_word(lsv_pkg::ReqFill, 4'd0, 1'b0, 1'b1, 16'hFFFF, 16'h0001, 16'hFFFF));
    send_word(make_word(lsv_pkg::ReqFill, 4'd0, 1'b0, 1'b0, 16'hFFFF, 16'h8000, 16'hFFFF));
  endtask

  // Retry loop under several limits, including zero and past the maximum.
  task automatic test_attempt_limits();
    write_limit(3'd4);
    send_word(make_word(lsv_pkg::ReqFill, 4'd0, 1'b0, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_word(make_word(lsv_pkg::ReqFill, 4'd0, 1'b0, 1'b0, 16'hFFFF, 16'h00F0, 16'h0030));
    write_limit(3'd0);
    send_word(make_word(lsv_pkg::ReqFill, 4'd0, 1'b0, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    write_limit(3'd7);
    send_word(make_word(lsv_pkg::ReqFill, 4'd0, 1'b0, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    write_limit(3'd2);
    send_word(make_word(lsv_pkg::ReqFill, 4'd0, 1'b0, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    write_limit(3'd3);
    send_word(make_word(lsv_pkg::ReqFill, 4'd0, 1'b0, 1'b0, 16'hFFFF, 16'hFFFF, 16'h0000));
  endtask

  // Random traffic, one phase per limit setting.
  task automatic test_random_traffic();
    logic [lsv_pkg::CfgW-1:0] limits[8];
    limits = '{3'd2, 3'd7, 3'd0, 3'd3, 3'd4, 3'd1, 3'd5, 3'd6};
    foreach (limits[k]) begin
      write_limit(limits[k]);
      repeat (WordsPerLimit) send_word(random_word());
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------

  initial begin
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_wdata_i        = '0;
    start              = 1'b0;
    req_type_i         = 1'b0;
    way_index_i        = '0;
    write_access_i     = 1'b0;
    l3_hit_i           = 1'b0;
    valid_mask_i       = '0;
    replaceable_mask_i = '0;
    in_lower_mask_i    = '0;
    fault_count        = 0;
    burst_left         = 0;
    // Reset state: way i holds age i, loop bits clear, one attempt.
    for (int i = 0; i < Ways; i++) begin
      pred_age[i]  = i;
      pred_loop[i] = 1'b0;
    end
    pred_limit = int'(lsv_pkg::AttemptLimitRst);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_access_extremes();
    test_fill_free_way();
    test_fill_full_set();
    test_attempt_limits();
    test_random_traffic();

    // Let the last words come home, then watch for strays.
    drain_words();
    repeat (TailCycles) @(posedge clk_i);
    if (pending_victims.size() != 0) note_fault("predicted result words never arrived");

    if (fault_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
